### rtl/core/max_heap_priority_queue_assert.svh
// assertion macros for the max heap priority queue checker
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// condition holds in the same cycle
`define MHPQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mhpq check failed");

// condition holds in the next cycle
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mhpq check failed");

`endif

### rtl/core/mhpq_pkg.sv
package mhpq_pkg;

	localparam int DATA_W  = 32;
	localparam int ENTRY_W = 11;

	// opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// finish report from the sift engine
	typedef struct packed {
		logic              fin;
		logic [1:0]        status;
		logic [DATA_W-1:0] popped;
	} fin_t;

endpackage

### rtl/core/mhpq_ram.sv
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata0_q;
	logic [WIDTH-1:0] rdata1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0_q <= mem_q[raddr0];
		rdata1_q <= mem_q[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

### rtl/core/mhpq_sift.sv
module mhpq_sift #(
	parameter int CAPACITY = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            opcode,
	input  logic signed [mhpq_pkg::DATA_W-1:0] value,
	output logic                            busy,
	// heap memory
	output logic                            we,
	output logic [$clog2(CAPACITY)-1:0]     waddr,
	output logic [mhpq_pkg::DATA_W-1:0]     wdata,
	output logic [$clog2(CAPACITY)-1:0]     raddr0,
	output logic [$clog2(CAPACITY)-1:0]     raddr1,
	input  logic [mhpq_pkg::DATA_W-1:0]     rdata0,
	input  logic [mhpq_pkg::DATA_W-1:0]     rdata1,
	// root mirror and status
	input  logic [mhpq_pkg::DATA_W-1:0]     root,
	output logic [$clog2(CAPACITY+1)-1:0]   count,
	output mhpq_pkg::fin_t                  fin
);
	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = AW + 1;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_UP_CHK  = 3'd1;
	localparam logic [2:0] S_UP_CMP  = 3'd2;
	localparam logic [2:0] S_DN_LAST = 3'd3;
	localparam logic [2:0] S_DN_CHK  = 3'd4;
	localparam logic [2:0] S_DN_CMP  = 3'd5;
	localparam logic [2:0] S_FIN     = 3'd6;

	logic [2:0]               state_q;
	logic [AW-1:0]            pos_q;
	logic signed [DATA_W-1:0] v_q;
	logic [CW-1:0]            count_q;
	logic [DATA_W-1:0]        popped_q;
	logic [1:0]               status_q;

	logic [AW-1:0]            parent;
	logic [EW-1:0]            lc_e;
	logic [EW-1:0]            rc_e;
	logic [EW-1:0]            count_e;
	logic                     lc_ok;
	logic                     rc_ok;
	logic signed [DATA_W-1:0] d0;
	logic signed [DATA_W-1:0] d1;
	logic                     take_l;
	logic                     take_r;
	logic signed [DATA_W-1:0] best_l;
	logic                     accept;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign parent  = AW'((pos_q - AW'(1)) >> 1);
	assign lc_e    = {pos_q, 1'b1};
	assign rc_e    = lc_e + EW'(1);
	assign count_e = EW'(count_q);
	assign lc_ok   = lc_e < count_e;
	assign rc_ok   = rc_e < count_e;
	assign d0      = $signed(rdata0);
	assign d1      = $signed(rdata1);
	assign take_l  = d0 > v_q;
	assign best_l  = take_l ? d0 : v_q;
	assign take_r  = rc_ok && (d1 > best_l);

	// memory port control
	always_comb begin
		we     = 1'b0;
		waddr  = pos_q;
		wdata  = v_q;
		raddr0 = AW'(lc_e);
		raddr1 = AW'(rc_e);
		unique case (state_q)
			S_IDLE: begin
				raddr0 = AW'(count_q - CW'(1));
			end
			S_UP_CHK: begin
				raddr0 = parent;
				we     = (pos_q == '0);
			end
			S_UP_CMP: begin
				we    = 1'b1;
				wdata = (v_q > d0) ? rdata0 : v_q;
			end
			S_DN_CHK: begin
				we = !lc_ok;
			end
			S_DN_CMP: begin
				we    = 1'b1;
				wdata = take_r ? rdata1 : (take_l ? rdata0 : v_q);
			end
			S_DN_LAST, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						popped_q <= '0;
						status_q <= ST_OK;
						pos_q    <= AW'(count_q);
						v_q      <= value;
						state_q  <= S_FIN;
						if (opcode == OP_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
								state_q <= S_UP_CHK;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								popped_q <= root;
								count_q  <= count_q - CW'(1);
								if (count_q != CW'(1)) begin
									state_q <= S_DN_LAST;
								end
							end
						end
					end
				end
				S_UP_CHK: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (v_q > d0) begin
						pos_q   <= parent;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN_LAST: begin
					v_q     <= d0;
					pos_q   <= '0;
					state_q <= S_DN_CHK;
				end
				S_DN_CHK: begin
					state_q <= lc_ok ? S_DN_CMP : S_FIN;
				end
				S_DN_CMP: begin
					if (take_r) begin
						pos_q   <= AW'(rc_e);
						state_q <= S_DN_CHK;
					end else if (take_l) begin
						pos_q   <= AW'(lc_e);
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign count      = count_q;
	assign fin.fin    = (state_q == S_FIN);
	assign fin.status = status_q;
	assign fin.popped = popped_q;

endmodule

### rtl/core/max_heap_priority_queue.sv
// binary max-heap priority queue of signed 32-bit values, one result beat per command
// insert: the new leaf climbs, a check and a compare per level, until the root or a parent not smaller
// pop: a pop of the last entry goes straight to the result, else the last entry sifts down from the root
// each sift level is a read of the heap memory followed by a write
// one command in flight, the next is taken in the result beat cycle; results cannot be stalled
// async active-low reset empties the queue; heap memory contents stay undefined until written
module max_heap_priority_queue #(
	parameter int CAPACITY = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command side
	input  logic                               start,
	output logic                               busy,
	input  logic                               opcode,
	input  logic signed [mhpq_pkg::DATA_W-1:0] value,
	// result side
	output logic                               done,
	output logic signed [mhpq_pkg::DATA_W-1:0] popped_value,
	output logic signed [mhpq_pkg::DATA_W-1:0] top_value,
	output logic [mhpq_pkg::ENTRY_W-1:0]       entry_count,
	output logic [1:0]                         status
);
	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// heap memory port wires
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [AW-1:0]     raddr0;
	logic [AW-1:0]     raddr1;
	logic [DATA_W-1:0] rdata0;
	logic [DATA_W-1:0] rdata1;

	logic [CW-1:0]     count;
	fin_t              fin;

	// mirror of heap entry zero so the top is visible without a memory read
	logic [DATA_W-1:0] root_q;

	// result beat register
	logic               done_q;
	logic [DATA_W-1:0]  popped_q;
	logic [DATA_W-1:0]  top_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [1:0]         status_q;

	// heap storage: one write port, two registered read ports (both children of a node)
	mhpq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_mhpq_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	// sift-up / sift-down sequencer, moves a hole through the heap one level at a time
	mhpq_sift #(
		.CAPACITY(CAPACITY)
	) u_mhpq_sift (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(opcode),
		.value (value),
		.busy  (busy),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rdata0),
		.rdata1(rdata1),
		.root  (root_q),
		.count (count),
		.fin   (fin)
	);

	// track every write that lands on the root
	always_ff @(posedge clk) begin
		if (we && (waddr == '0)) begin
			root_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.fin;
		end
	end

	// all memory writes of the command are complete when fin is raised
	always_ff @(posedge clk) begin
		if (fin.fin) begin
			popped_q <= fin.popped;
			top_q    <= (count == '0) ? '0 : root_q;
			entry_q  <= ENTRY_W'(count);
			status_q <= fin.status;
		end
	end

	assign done         = done_q;
	assign popped_value = $signed(popped_q);
	assign top_value    = $signed(top_q);
	assign entry_count  = entry_q;
	assign status       = status_q;

endmodule

### rtl/core/mhpq_checker.sv
`include "max_heap_priority_queue_assert.svh"

module mhpq_checker #(
	parameter int CAPACITY = 1024
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic signed [mhpq_pkg::DATA_W-1:0] popped_value,
	input logic signed [mhpq_pkg::DATA_W-1:0] top_value,
	input logic [mhpq_pkg::ENTRY_W-1:0]       entry_count,
	input logic [1:0]                         status
);
	import mhpq_pkg::*;

	// an accepted command keeps the block busy until its result beat
	`MHPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// the result beat arrives only once the sequencer is back to idle
	`MHPQ_ASSERT_SAME(a_done_idle, done, !busy)

	// empty pop reports nothing stored and nothing removed
	`MHPQ_ASSERT_SAME(a_empty_pop, done && (status == ST_EMPTY),
		(entry_count == '0) && (popped_value == '0) && (top_value == '0))

	// a dropped insert happens only at capacity and removes nothing
	`MHPQ_ASSERT_SAME(a_full_drop, done && (status == ST_FULL),
		(popped_value == '0) && ((CAPACITY > 2047) || (entry_count == ENTRY_W'(CAPACITY))))

	// an empty queue has no top
	`MHPQ_ASSERT_SAME(a_empty_top, done && (entry_count == '0), top_value == '0)

endmodule

bind max_heap_priority_queue mhpq_checker #(
	.CAPACITY(CAPACITY)
) u_mhpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.popped_value(popped_value),
	.top_value   (top_value),
	.entry_count (entry_count),
	.status      (status)
);
